### rtl/core/rfd_pkg.sv
// ----------------------------------------------------------------------------
// rfd_pkg
// Shared types, codes and frame unpacking for the remote frame decoder.
// ----------------------------------------------------------------------------
package rfd_pkg;

   // Item action codes
   localparam logic [1:0] ACT_BYTE = 2'd0;
   localparam logic [1:0] ACT_IDLE = 2'd1;
   localparam logic [1:0] ACT_TICK = 2'd2;

   // Configuration register indexes
   localparam logic [1:0] CSR_CENTER   = 2'd0;
   localparam logic [1:0] CSR_DEADBAND = 2'd1;
   localparam logic [1:0] CSR_SETTLE   = 2'd2;
   localparam logic [1:0] CSR_OFFLINE  = 2'd3;

   localparam int CSR_DATA_W = 11;
   localparam int STICK_W    = 11;

   // Reset values of the configuration registers
   localparam logic [10:0] CENTER_RESET   = 11'd1024;
   localparam logic [9:0]  DEADBAND_RESET = 10'd8;
   localparam logic [3:0]  SETTLE_RESET   = 4'd10;
   localparam logic [3:0]  OFFLINE_RESET  = 4'd10;

   // Only the leading bytes of a frame carry decoded fields.
   localparam int DECODE_BYTES = 16;
   localparam int DECODE_IDX_W = $clog2(DECODE_BYTES);

   // Status bit positions
   localparam int STAT_FRAME   = 0;
   localparam int STAT_SETTLED = 1;
   localparam int STAT_OFFLINE = 2;

   typedef logic [3:0][STICK_W-1:0] stick_array_type;
   typedef logic [DECODE_BYTES-1:0][7:0] frame_buf_type;

   typedef struct packed {
      logic [10:0] center;
      logic [9:0]  deadband;
      logic [3:0]  settle_ticks;
      logic [3:0]  offline_ticks;
   } cfg_type;

   typedef struct packed {
      logic settled;
      logic offline;
   } watch_type;

   typedef struct packed {
      stick_array_type  sticks;
      logic [1:0]       switch_left;
      logic [1:0]       switch_right;
      logic [2:0][15:0] mouse;
      logic [15:0]      buttons;
      logic [15:0]      keys;
   } frame_type;

   // Sticks are packed as a little-endian stream of 11-bit values.
   function automatic frame_type rfd_unpack(input frame_buf_type b);
      frame_type f;
      f.sticks[0]    = {b[1][2:0], b[0]};
      f.sticks[1]    = {b[2][5:0], b[1][7:3]};
      f.sticks[2]    = {b[4][0], b[3], b[2][7:6]};
      f.sticks[3]    = {b[5][3:0], b[4][7:1]};
      f.switch_left  = b[5][7:6];
      f.switch_right = b[5][5:4];
      f.mouse[0]     = {b[7], b[6]};
      f.mouse[1]     = {b[9], b[8]};
      f.mouse[2]     = {b[11], b[10]};
      f.buttons      = {b[13], b[12]};
      f.keys         = {b[15], b[14]};
      return f;
   endfunction

endpackage

### rtl/core/rfd_watch.sv
// ----------------------------------------------------------------------------
// rfd_watch
// Stick settle counter and link offline counter, both run by ticks.
// ----------------------------------------------------------------------------
module rfd_watch import rfd_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            tick_go,
   input  logic            idle_go,
   input  stick_array_type raw_sticks,
   input  cfg_type         cfg,
   output watch_type       flags_next
);

   logic [3:0] settle_count_ff, settle_count_in;
   logic       settled_ff, settled_in;
   logic [3:0] idle_ticks_ff, idle_ticks_in;
   logic       offline_ff, offline_in;

   logic [3:0]         centred;
   logic [STICK_W-1:0] stick_gap [4];
   logic               all_centred;
   logic [4:0]         settle_inc;
   logic [4:0]         idle_inc;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         stick_gap[i] = (raw_sticks[i] >= cfg.center) ? raw_sticks[i] - cfg.center
                                                      : cfg.center - raw_sticks[i];
         centred[i] = stick_gap[i] <= STICK_W'(cfg.deadband);
      end
      all_centred = &centred;
   end

   always_comb begin
      settle_count_in = settle_count_ff;
      settled_in      = settled_ff;
      idle_ticks_in   = idle_ticks_ff;
      offline_in      = offline_ff;
      settle_inc      = {1'b0, settle_count_ff} + 5'd1;
      idle_inc        = {1'b0, idle_ticks_ff} + 5'd1;
      if (tick_go) begin
         if (all_centred) begin
            if (settle_inc >= {1'b0, cfg.settle_ticks}) begin
               settle_count_in = cfg.settle_ticks;
               settled_in      = 1'b1;
            end else begin
               settle_count_in = settle_inc[3:0];
            end
         end else begin
            settle_count_in = '0;
            settled_in      = 1'b0;
         end
         if (idle_inc >= {1'b0, cfg.offline_ticks}) begin
            idle_ticks_in = cfg.offline_ticks;
            offline_in    = 1'b1;
         end else begin
            idle_ticks_in = idle_inc[3:0];
            offline_in    = 1'b0;
         end
      end else if (idle_go) begin
         // The offline flag itself waits for the next tick.
         idle_ticks_in = '0;
      end
   end

   assign flags_next.settled = settled_in;
   assign flags_next.offline = offline_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_count_ff <= '0;
         settled_ff      <= 1'b0;
         idle_ticks_ff   <= '0;
         offline_ff      <= 1'b0;
      end else begin
         settle_count_ff <= settle_count_in;
         settled_ff      <= settled_in;
         idle_ticks_ff   <= idle_ticks_in;
         offline_ff      <= offline_in;
      end
   end

endmodule

### rtl/core/remote_frame_decoder_with_stick_settle_top.sv
// ----------------------------------------------------------------------------
// remote_frame_decoder_with_stick_settle_top
// Remote control frame decoder with stick settle and link offline watch.
//
//   Channel  Direction  Handshake          Payload
//   req      in         req_valid/stall    action, rx_byte
//   rsp      out        rsp_valid/stall    sticks, switches, mouse, keys, status
//   csr      in         csr_we             csr_index, csr_wdata
//
// One item per cycle is taken while req_stall is low; a result is registered in the result register.
// An input register and a result register part the two sides, so one item can
// be taken while a result waits. Byte items never produce a result.
// Reset is synchronous and clears the counters, flags and decoded fields; the
// byte buffer is read only after a full refill, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module remote_frame_decoder_with_stick_settle_top import rfd_pkg::*; #(
   parameter int FRAME_BYTES = 18
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_action,
   input  logic [7:0]            req_rx_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [10:0]           rsp_stick_ch0,
   output logic [10:0]           rsp_stick_ch1,
   output logic [10:0]           rsp_stick_ch2,
   output logic [10:0]           rsp_stick_ch3,
   output logic [1:0]            rsp_switch_left,
   output logic [1:0]            rsp_switch_right,
   output logic signed [15:0]    rsp_mouse_x,
   output logic signed [15:0]    rsp_mouse_y,
   output logic signed [15:0]    rsp_mouse_z,
   output logic [15:0]           rsp_mouse_buttons,
   output logic [15:0]           rsp_key_bits,
   output logic [2:0]            rsp_status,
   input  logic                  csr_we,
   input  logic [1:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int CNT_W = $clog2(FRAME_BYTES + 2);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FRAME_BYTES);
   localparam logic [CNT_W-1:0] CNT_OVER = CNT_W'(FRAME_BYTES + 1);
   localparam logic [CNT_W-1:0] CNT_DEC  = CNT_W'(DECODE_BYTES);

   cfg_type cfg_ff, cfg_in;

   logic       s1_valid_ff, s1_valid_in;
   logic [1:0] s1_action_ff;
   logic [7:0] s1_byte_ff;

   logic [CNT_W-1:0] rx_count_ff, rx_count_in;
   frame_buf_type    rx_buf_ff, rx_buf_in;

   stick_array_type  raw_ff, raw_in;
   stick_array_type  held_ff, held_in;
   logic [1:0]       sw_left_ff, sw_left_in;
   logic [1:0]       sw_right_ff, sw_right_in;
   logic [2:0][15:0] mouse_ff, mouse_in;
   logic [15:0]      buttons_ff, buttons_in;
   logic [15:0]      keys_ff, keys_in;

   logic             rsp_valid_ff, rsp_valid_in;
   stick_array_type  out_sticks_ff;
   logic [1:0]       out_sw_left_ff, out_sw_right_ff;
   logic [2:0][15:0] out_mouse_ff;
   logic [15:0]      out_buttons_ff, out_keys_ff;
   logic [2:0]       out_status_ff, out_status_in;

   logic      needs_out, out_free, s1_go, out_load;
   logic      byte_go, idle_go, tick_go, frame_ok;
   frame_type frame;
   watch_type flags;

   // Configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_CENTER:   cfg_in.center        = csr_wdata[10:0];
            CSR_DEADBAND: cfg_in.deadband      = csr_wdata[9:0];
            CSR_SETTLE:   cfg_in.settle_ticks  = csr_wdata[3:0];
            CSR_OFFLINE:  cfg_in.offline_ticks = csr_wdata[3:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   // Handshake: the held item moves on unless it needs the result register
   // and that register is still waiting to be taken.
   always_comb begin
      needs_out = (s1_action_ff == ACT_IDLE) || (s1_action_ff == ACT_TICK);
      out_free  = !rsp_valid_ff || !rsp_stall;
      s1_go     = s1_valid_ff && (out_free || !needs_out);
      out_load  = s1_go && needs_out;
      req_stall = s1_valid_ff && !s1_go;
      byte_go   = s1_go && (s1_action_ff == ACT_BYTE);
      idle_go   = s1_go && (s1_action_ff == ACT_IDLE);
      tick_go   = s1_go && (s1_action_ff == ACT_TICK);
      s1_valid_in  = (req_valid && !req_stall) || (s1_valid_ff && !s1_go);
      rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);
   end

   // Byte collection
   always_comb begin
      rx_count_in = rx_count_ff;
      rx_buf_in   = rx_buf_ff;
      if (byte_go) begin
         if (rx_count_ff < CNT_FULL) begin
            if (rx_count_ff < CNT_DEC) begin
               rx_buf_in[rx_count_ff[DECODE_IDX_W-1:0]] = s1_byte_ff;
            end
            rx_count_in = rx_count_ff + CNT_W'(1);
         end else begin
            rx_count_in = CNT_OVER;
         end
      end else if (idle_go) begin
         rx_count_in = '0;
      end
   end

   assign frame    = rfd_unpack(rx_buf_ff);
   assign frame_ok = idle_go && (rx_count_ff == CNT_FULL);

   rfd_watch u_watch (
      .clock      (clock),
      .reset      (reset),
      .tick_go    (tick_go),
      .idle_go    (idle_go),
      .raw_sticks (raw_ff),
      .cfg        (cfg_ff),
      .flags_next (flags)
   );

   // Decoded state. An idle leaves the settled flag as it is, so the next
   // flag equals the current one whenever a frame is unpacked.
   always_comb begin
      raw_in      = raw_ff;
      held_in     = held_ff;
      sw_left_in  = sw_left_ff;
      sw_right_in = sw_right_ff;
      mouse_in    = mouse_ff;
      buttons_in  = buttons_ff;
      keys_in     = keys_ff;
      if (frame_ok) begin
         raw_in      = frame.sticks;
         sw_left_in  = frame.switch_left;
         sw_right_in = frame.switch_right;
         mouse_in    = frame.mouse;
         buttons_in  = frame.buttons;
         keys_in     = frame.keys;
         for (int i = 0; i < 4; i++) begin
            held_in[i] = flags.settled ? cfg_ff.center : frame.sticks[i];
         end
      end
      out_status_in               = '0;
      out_status_in[STAT_FRAME]   = frame_ok;
      out_status_in[STAT_SETTLED] = flags.settled;
      out_status_in[STAT_OFFLINE] = flags.offline;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.center        <= CENTER_RESET;
         cfg_ff.deadband      <= DEADBAND_RESET;
         cfg_ff.settle_ticks  <= SETTLE_RESET;
         cfg_ff.offline_ticks <= OFFLINE_RESET;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rx_count_ff  <= '0;
         raw_ff       <= '0;
         held_ff      <= '0;
         sw_left_ff   <= '0;
         sw_right_ff  <= '0;
         mouse_ff     <= '0;
         buttons_ff   <= '0;
         keys_ff      <= '0;
      end else begin
         cfg_ff       <= cfg_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         rx_count_ff  <= rx_count_in;
         raw_ff       <= raw_in;
         held_ff      <= held_in;
         sw_left_ff   <= sw_left_in;
         sw_right_ff  <= sw_right_in;
         mouse_ff     <= mouse_in;
         buttons_ff   <= buttons_in;
         keys_ff      <= keys_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rx_buf_ff <= rx_buf_in;
      if (req_valid && !req_stall) begin
         s1_action_ff <= req_action;
         s1_byte_ff   <= req_rx_byte;
      end
      if (out_load) begin
         out_sticks_ff   <= held_in;
         out_sw_left_ff  <= sw_left_in;
         out_sw_right_ff <= sw_right_in;
         out_mouse_ff    <= mouse_in;
         out_buttons_ff  <= buttons_in;
         out_keys_ff     <= keys_in;
         out_status_ff   <= out_status_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_stick_ch0     = out_sticks_ff[0];
   assign rsp_stick_ch1     = out_sticks_ff[1];
   assign rsp_stick_ch2     = out_sticks_ff[2];
   assign rsp_stick_ch3     = out_sticks_ff[3];
   assign rsp_switch_left   = out_sw_left_ff;
   assign rsp_switch_right  = out_sw_right_ff;
   assign rsp_mouse_x       = $signed(out_mouse_ff[0]);
   assign rsp_mouse_y       = $signed(out_mouse_ff[1]);
   assign rsp_mouse_z       = $signed(out_mouse_ff[2]);
   assign rsp_mouse_buttons = out_buttons_ff;
   assign rsp_key_bits      = out_keys_ff;
   assign rsp_status        = out_status_ff;

   // The byte count never passes the overlong mark.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rx_count_ff <= CNT_OVER)
      else $error("rx byte count out of range");

   // Any idle clears the byte count by the next cycle.
   a_idle_clears: assert property (@(posedge clock) disable iff (reset)
      idle_go |=> (rx_count_ff == '0))
      else $error("idle did not clear byte count");

   // A byte item never loads the result register.
   a_byte_no_result: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && (s1_action_ff == ACT_BYTE)) |-> !out_load)
      else $error("byte item produced a result");

   // A result that is still waiting is never overwritten.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !out_load)
      else $error("pending result overwritten");

endmodule
